// ===== rtl/bsc_pkg.sv =====
// Package for the bubble sort block: sizes, counter limits and the queue entry types.
// Used by the interfaces, the front, queue, back and top level.
// No dependencies.
package bsc_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int VALUE_W      = 32;
  localparam int OPS_W        = 11;
  localparam logic [OPS_W-1:0] OPS_MAX = '1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // One classified request as it travels from the front to the back
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      keep;   // room was left, store the value
    logic                      ovf;    // list lost a request (meaningful with last)
  } bsc_entry_t;

  typedef struct packed {
    logic       valid;
    bsc_entry_t entry;
  } bsc_push_t;

  typedef struct packed {
    logic       valid;
    bsc_entry_t entry;
  } bsc_head_t;

endpackage

// ===== rtl/bsc_in_if.sv =====
// Input channel: one list element per request, with an end-of-list flag.
// Depends on bsc_pkg for the value width.
interface bsc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsc_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

// ===== rtl/bsc_out_if.sv =====
// Output channel: sorted values, with the operation counts on the final one.
// Depends on bsc_pkg for the value and counter widths.
interface bsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsc_pkg::VALUE_W-1:0] sorted_value;
  logic                               last_out;
  logic [bsc_pkg::OPS_W-1:0]          comparisons;
  logic [bsc_pkg::OPS_W-1:0]          swap_count;
  logic                               truncated;

  modport source (output valid, sorted_value, last_out, comparisons, swap_count, truncated,
                  input ready);
  modport sink (input valid, sorted_value, last_out, comparisons, swap_count, truncated,
                output ready);
endinterface

// ===== rtl/bubble_sort_with_counts.sv =====
// Top level of the bubble sort block: front end, request queue and sorting back end.
// Depends on bsc_pkg, bsc_in_if, bsc_out_if, bsc_front, bsc_queue and bsc_back.
//
// Usage:
//   item   (valid/ready): one signed 32-bit value per request, last = 1 on the
//          final element of a list. Up to 64 elements are kept; later ones are
//          dropped and reported through truncated on the final result.
//   result (valid/ready): the kept elements in ascending order, one per request.
//          last_out marks the final one, which also carries comparisons,
//          swap_count and truncated; these read 0 on every other result.
// Operation:
//   Each stored element is written to the store as its request is taken. After
//   the final request, each pass over the unsorted prefix does one compare a
//   cycle, limited by the single store read port, and the prefix shrinks by one
//   per pass; each value is then read from the store and loaded for output.
//   A four-entry queue lets the start of the next list enter while the current one sorts.
// Reset: synchronous rst empties the queue and drops any list in progress;
//   the store needs no clearing. A stalled receiver holds the current result
//   in the output register and pauses the back end; the front keeps taking
//   requests until the queue fills.
module bubble_sort_with_counts (
  input  logic      clk,
  input  logic      rst,
  bsc_in_if.sink    item,
  bsc_out_if.source result
);

  bsc_pkg::bsc_push_t push;
  bsc_pkg::bsc_head_t head;
  logic               full;
  logic               pop;

  bsc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .full (full),
    .push (push)
  );

  bsc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .pop  (pop),
    .head (head)
  );

  bsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== rtl/bsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bsc_front.sv =====
// Front end: accepts list elements, decides store or drop, and pushes the request.
// Depends on bsc_pkg and bsc_in_if.
module bsc_front (
  input  logic                clk,
  input  logic                rst,
  bsc_in_if.sink              item,
  input  logic                full,
  output bsc_pkg::bsc_push_t  push
);

  logic [bsc_pkg::CNT_W-1:0] count;
  logic                      ovf;
  logic                      keep;
  logic                      accept;

  assign item.ready = !full;
  assign accept     = item.valid && item.ready;
  assign keep       = count < bsc_pkg::CNT_W'(bsc_pkg::MAX_ELEMENTS);

  // Classify the request for the back end
  always_comb begin
    push.valid       = accept;
    push.entry.value = item.value;
    push.entry.last  = item.last;
    push.entry.keep  = keep;
    push.entry.ovf   = ovf || !keep;
  end

  // Track fill level of the current list; restart on its final request
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= count + bsc_pkg::CNT_W'(keep);
        ovf   <= ovf || !keep;
      end
    end
  end

endmodule

// ===== rtl/bsc_queue.sv =====
// Short request queue between front and back end.
// Depends on bsc_pkg.
module bsc_queue (
  input  logic               clk,
  input  logic               rst,
  input  bsc_pkg::bsc_push_t push,
  output logic               full,
  input  logic               pop,
  output bsc_pkg::bsc_head_t head
);

  bsc_pkg::bsc_entry_t           slots [bsc_pkg::QUEUE_DEPTH];
  logic [bsc_pkg::QPTR_W-1:0]    wptr;
  logic [bsc_pkg::QPTR_W-1:0]    rptr;
  logic [bsc_pkg::QPTR_W:0]      used;
  logic                          push_en;
  logic                          pop_en;

  assign full       = used == (bsc_pkg::QPTR_W + 1)'(bsc_pkg::QUEUE_DEPTH);
  assign head.valid = used != '0;
  assign head.entry = slots[rptr];
  assign push_en    = push.valid && !full;
  assign pop_en     = pop && head.valid;

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wptr] <= push.entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push_en) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_en) begin
        rptr <= rptr + 1'b1;
      end
      used <= used + (bsc_pkg::QPTR_W + 1)'(push_en) - (bsc_pkg::QPTR_W + 1)'(pop_en);
    end
  end

endmodule

// ===== rtl/bsc_back.sv =====
// Back end: writes elements to the store, bubble-sorts them in place, streams them out.
// Depends on bsc_pkg, bsc_out_if and bsc_ram.
module bsc_back (
  input  logic               clk,
  input  logic               rst,
  input  bsc_pkg::bsc_head_t head,
  output logic               pop,
  bsc_out_if.source          result
);

  typedef enum logic [2:0] {
    IDLE, PASS_LOAD, PASS_CMP, PASS_END, EMIT_RD, EMIT_LD
  } state_t;

  state_t                              state;
  logic [bsc_pkg::CNT_W-1:0]           n;
  logic                                ovf;
  logic [bsc_pkg::CNT_W-1:0]           bound;
  logic [bsc_pkg::ADDR_W-1:0]          j;
  logic [bsc_pkg::ADDR_W-1:0]          k;
  logic signed [bsc_pkg::VALUE_W-1:0]  carry;
  logic                                swapped;
  logic [bsc_pkg::OPS_W-1:0]           cmp_cnt;
  logic [bsc_pkg::OPS_W-1:0]           swp_cnt;
  logic                                out_valid;
  logic signed [bsc_pkg::VALUE_W-1:0]  out_value;
  logic                                out_last;
  logic [bsc_pkg::OPS_W-1:0]           out_cmp;
  logic [bsc_pkg::OPS_W-1:0]           out_swp;
  logic                                out_trunc;

  logic                                we;
  logic [bsc_pkg::ADDR_W-1:0]          waddr;
  logic signed [bsc_pkg::VALUE_W-1:0]  wdata;
  logic                                re;
  logic [bsc_pkg::ADDR_W-1:0]          raddr;
  logic signed [bsc_pkg::VALUE_W-1:0]  rdata;

  logic                                take;
  logic [bsc_pkg::CNT_W-1:0]           n_next;
  logic [bsc_pkg::CNT_W-1:0]           j_inc;
  logic [bsc_pkg::CNT_W-1:0]           k_inc;
  logic [bsc_pkg::CNT_W-1:0]           bound_dec;
  logic                                fin;
  logic                                right_less;
  logic                                out_free;
  logic                                more_passes;
  logic [bsc_pkg::OPS_W-1:0]           cmp_inc;
  logic [bsc_pkg::OPS_W-1:0]           swp_inc;

  bsc_ram #(
    .WIDTH (bsc_pkg::VALUE_W),
    .DEPTH (bsc_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign take        = (state == IDLE) && head.valid;
  assign pop         = take;
  assign n_next      = n + bsc_pkg::CNT_W'(head.entry.keep);
  assign j_inc       = bsc_pkg::CNT_W'(j) + 1'b1;
  assign k_inc       = bsc_pkg::CNT_W'(k) + 1'b1;
  assign bound_dec   = bound - 1'b1;
  assign fin         = k_inc == n;
  assign right_less  = rdata < carry;
  assign out_free    = !out_valid || result.ready;
  assign more_passes = swapped && (bound_dec >= bsc_pkg::CNT_W'(2));
  assign cmp_inc     = (cmp_cnt == bsc_pkg::OPS_MAX) ? cmp_cnt : cmp_cnt + 1'b1;
  assign swp_inc     = (swp_cnt == bsc_pkg::OPS_MAX) ? swp_cnt : swp_cnt + 1'b1;

  assign result.valid        = out_valid;
  assign result.sorted_value = out_value;
  assign result.last_out     = out_last;
  assign result.comparisons  = out_cmp;
  assign result.swap_count   = out_swp;
  assign result.truncated    = out_trunc;

  // Drive the store ports: one write and one read per cycle at most
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = carry;
    re    = 1'b0;
    raddr = '0;
    case (state)
      IDLE: begin
        if (take && head.entry.keep) begin
          we    = 1'b1;
          waddr = n[bsc_pkg::ADDR_W-1:0];
          wdata = head.entry.value;
        end
        // start the first pass by fetching element 0
        if (take && head.entry.last && n_next >= bsc_pkg::CNT_W'(2)) begin
          re = 1'b1;
        end
      end
      PASS_LOAD: begin
        re    = 1'b1;
        raddr = bsc_pkg::ADDR_W'(1);
      end
      PASS_CMP: begin
        // the smaller of the pair settles at j-1, the larger rides on in carry
        we    = 1'b1;
        waddr = j - 1'b1;
        wdata = right_less ? rdata : carry;
        if (j_inc < bound) begin
          re    = 1'b1;
          raddr = j + 1'b1;
        end
      end
      PASS_END: begin
        we    = 1'b1;
        waddr = bound_dec[bsc_pkg::ADDR_W-1:0];
        wdata = carry;
        re    = more_passes;
      end
      EMIT_RD: begin
        re    = 1'b1;
        raddr = k;
      end
      default: ;
    endcase
  end

  // Sequence store, sort passes and output stream
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      n         <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == EMIT_LD && out_free) begin
        out_valid <= 1'b1;
        out_value <= rdata;
        out_last  <= fin;
        out_cmp   <= fin ? cmp_cnt : '0;
        out_swp   <= fin ? swp_cnt : '0;
        out_trunc <= fin && ovf;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (take) begin
            n <= n_next;
            if (head.entry.last) begin
              ovf     <= head.entry.ovf;
              cmp_cnt <= '0;
              swp_cnt <= '0;
              k       <= '0;
              bound   <= n_next;
              state   <= (n_next >= bsc_pkg::CNT_W'(2)) ? PASS_LOAD : EMIT_RD;
            end
          end
        end
        PASS_LOAD: begin
          carry   <= rdata;
          j       <= bsc_pkg::ADDR_W'(1);
          swapped <= 1'b0;
          state   <= PASS_CMP;
        end
        PASS_CMP: begin
          cmp_cnt <= cmp_inc;
          if (right_less) begin
            swp_cnt <= swp_inc;
            swapped <= 1'b1;
          end else begin
            carry <= rdata;
          end
          if (j_inc < bound) begin
            j <= j + 1'b1;
          end else begin
            state <= PASS_END;
          end
        end
        PASS_END: begin
          // stop after a clean pass or when one element is left unsorted
          if (more_passes) begin
            bound <= bound_dec;
            state <= PASS_LOAD;
          end else begin
            state <= EMIT_RD;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          if (out_free) begin
            if (fin) begin
              n     <= '0;
              ovf   <= 1'b0;
              state <= IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= EMIT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bsc_checker.sv =====
// Port-level checks on the result stream of the bubble sort block, bound to the top level.
// Depends on bsc_pkg for the counter width.
module bsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      result_valid,
  input logic                      last_out,
  input logic [bsc_pkg::OPS_W-1:0] comparisons,
  input logic [bsc_pkg::OPS_W-1:0] swap_count,
  input logic                      truncated
);

  // Counts and overflow flag appear only on the final result of a list
  a_summary_only_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_out |-> comparisons == '0 && swap_count == '0 && !truncated)
    else $error("summary fields set on a non-final result");

  // Every swap follows a comparison
  a_swaps_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_out |-> swap_count <= comparisons)
    else $error("swap count exceeds comparison count");

  // A list of one or more sorted values with swaps must have compared
  a_swaps_need_compare: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_out && swap_count != '0 |-> comparisons != '0)
    else $error("swaps reported without comparisons");

  // Reset empties the output register
  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind bubble_sort_with_counts bsc_checker u_bsc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .last_out     (result.last_out),
  .comparisons  (result.comparisons),
  .swap_count   (result.swap_count),
  .truncated    (result.truncated)
);

// ===== verif/bsc_sort_checker.sv =====
// Checker for the bubble sort block: watches both channels, predicts the sorted
// results with their operation counts and compares every accepted result.
// Depends on bsc_pkg, bsc_in_if and bsc_out_if.
module bsc_sort_checker (
  input  logic clk,
  input  logic rst,
  bsc_in_if    item,
  bsc_out_if   result,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [bsc_pkg::VALUE_W-1:0] sorted_value;
    logic                               last_out;
    logic [bsc_pkg::OPS_W-1:0]          comparisons;
    logic [bsc_pkg::OPS_W-1:0]          swap_count;
    logic                               truncated;
  } sorted_rec_t;

  sorted_rec_t                        sorted_due[$];
  logic signed [bsc_pkg::VALUE_W-1:0] list_buf [bsc_pkg::MAX_ELEMENTS];
  int                                 list_len;
  bit                                 list_dropped;
  int                                 mismatches;

  initial begin
    list_len     = 0;
    list_dropped = 0;
    mismatches   = 0;
    fail_count   = 0;
    pending      = 0;
  end

  // Clamp an operation count to the width of the result field
  function automatic logic [bsc_pkg::OPS_W-1:0] clamp_ops(int n);
    return (n > int'(bsc_pkg::OPS_MAX)) ? bsc_pkg::OPS_MAX : bsc_pkg::OPS_W'(n);
  endfunction

  // Bubble-sort the collected list, counting compares and swaps, and queue the results
  function automatic void sort_and_queue();
    int                                 cmp_total;
    int                                 swap_total;
    int                                 pass_no;
    bit                                 swapped;
    logic signed [bsc_pkg::VALUE_W-1:0] tmp;
    sorted_rec_t                        rec;
    cmp_total  = 0;
    swap_total = 0;
    pass_no    = 0;
    swapped    = 1;
    while (swapped && pass_no < list_len - 1) begin
      swapped = 0;
      for (int j = 1; j < list_len - pass_no; j++) begin
        cmp_total++;
        if (list_buf[j] < list_buf[j-1]) begin
          tmp           = list_buf[j];
          list_buf[j]   = list_buf[j-1];
          list_buf[j-1] = tmp;
          swap_total++;
          swapped = 1;
        end
      end
      pass_no++;
    end
    for (int k = 0; k < list_len; k++) begin
      rec.sorted_value = list_buf[k];
      rec.last_out     = (k == list_len - 1);
      rec.comparisons  = rec.last_out ? clamp_ops(cmp_total) : '0;
      rec.swap_count   = rec.last_out ? clamp_ops(swap_total) : '0;
      rec.truncated    = rec.last_out && list_dropped;
      sorted_due.insert(sorted_due.size(), rec);
    end
    list_len     = 0;
    list_dropped = 0;
  endfunction

  // Report one field that differs from its prediction
  function automatic void check_field(string name, logic signed [bsc_pkg::VALUE_W-1:0] want,
                                      logic signed [bsc_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    sorted_rec_t want;
    if (rst) begin
      sorted_due.delete();
      list_len     = 0;
      list_dropped = 0;
    end else begin
      // Compare an accepted result with the oldest prediction
      if (result.valid && result.ready) begin
        if (sorted_due.size() == 0) begin
          $error("sorted_value: expected none, actual %0d", result.sorted_value);
          mismatches++;
        end else begin
          want = sorted_due.pop_front();
          check_field("sorted_value", want.sorted_value, result.sorted_value);
          check_field("last_out", want.last_out, result.last_out);
          check_field("comparisons", want.comparisons, result.comparisons);
          check_field("swap_count", want.swap_count, result.swap_count);
          check_field("truncated", want.truncated, result.truncated);
        end
      end
      // Store or drop an accepted request; sort at the end of the list
      if (item.valid && item.ready) begin
        if (list_len < bsc_pkg::MAX_ELEMENTS) begin
          list_buf[list_len] = item.value;
          list_len++;
        end else begin
          list_dropped = 1;
        end
        if (item.last) sort_and_queue();
      end
    end
    fail_count <= mismatches;
    pending    <= sorted_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the bubble sort testbench: clock, reset, request and result traffic, verdict.
// Depends on bsc_pkg, bsc_in_if, bsc_out_if, bubble_sort_with_counts and bsc_sort_checker.
module tb_top;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_UP,
    FILL_DOWN,
    FILL_EXTREME
  } fill_pattern_t;

  localparam int ITEM_GOAL    = 480;
  localparam int QUIET_AFTER  = 420;
  localparam int HOLD_CYCLES  = 5000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic signed [bsc_pkg::VALUE_W-1:0] VAL_MAX =
    {1'b0, {(bsc_pkg::VALUE_W-1){1'b1}}};
  localparam logic signed [bsc_pkg::VALUE_W-1:0] VAL_MIN =
    {1'b1, {(bsc_pkg::VALUE_W-1){1'b0}}};

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   send_calm;
  bit   quiet;
  bit   hold_req;

  bsc_in_if  item_ch ();
  bsc_out_if result_ch ();

  bubble_sort_with_counts dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  bsc_sort_checker chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up long after the slowest correct run
  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

  // Pick one list element for the given fill pattern
  function automatic logic signed [bsc_pkg::VALUE_W-1:0] pick_value(
    fill_pattern_t pat, logic signed [bsc_pkg::VALUE_W-1:0] base, int idx);
    case (pat)
      FILL_NARROW: return $signed(bsc_pkg::VALUE_W'($urandom_range(0, 8))) - 4;
      FILL_UP:     return base + idx;
      FILL_DOWN:   return base - idx;
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return '0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default:     return $urandom;
    endcase
  endfunction

  // Offer one request, with an occasional gap first, and hold it until accepted
  task automatic send_item(input logic signed [bsc_pkg::VALUE_W-1:0] v, input logic l);
    int gap;
    quiet = (items_sent >= QUIET_AFTER);
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(10, 60);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.last  <= l;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic send_list(input int len, input fill_pattern_t pat);
    logic signed [bsc_pkg::VALUE_W-1:0] base;
    base = $urandom;
    for (int i = 0; i < len; i++) send_item(pick_value(pat, base, i), i == len - 1);
  endtask

  // Receiver: one long hold-off when asked, random stall bursts, calm stretches
  initial begin
    int idle_left;
    int hold_left;
    int calm_left;
    bit hold_done;
    bit rdy;
    idle_left = 0;
    hold_left = 0;
    calm_left = 0;
    hold_done = 0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1;
        rdy = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rdy = 1'b0;
        if (idle_left == 0 && $urandom_range(0, 3) == 0) calm_left = $urandom_range(50, 300);
      end else if (calm_left > 0) begin
        calm_left--;
        rdy = 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        idle_left = $urandom_range(1, 19) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      result_ch.ready <= rdy;
      @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int            list_no;
    int            len;
    int            r;
    fill_pattern_t pat;
    items_sent = 0;
    send_calm  = 0;
    quiet      = 0;
    hold_req   = 0;
    rst            <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.value  <= '0;
    item_ch.last   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single-element lists at both ends of the range
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    // Two elements out of order
    send_item(5, 1'b0);
    send_item(-3, 1'b1);
    // Already sorted: one pass, no swap
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(1, 1'b1);
    // Equal values never swap
    repeat (3) send_item(7, 1'b0);
    send_item(7, 1'b1);
    // Extremes mixed
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);

    // Random lists: a full one and an overflowing one first, then mostly short lists
    hold_req = 1;
    list_no  = 0;
    while (items_sent < ITEM_GOAL) begin
      if (list_no == 0) begin
        len = bsc_pkg::MAX_ELEMENTS;
      end else if (list_no == 1) begin
        len = bsc_pkg::MAX_ELEMENTS + 3;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      len = $urandom_range(1, 12);
        else if (r < 75) len = $urandom_range(13, 40);
        else if (r < 85) len = bsc_pkg::MAX_ELEMENTS;
        else if (r < 93) len = $urandom_range(bsc_pkg::MAX_ELEMENTS + 1,
                                              bsc_pkg::MAX_ELEMENTS + 8);
        else             len = $urandom_range(2, bsc_pkg::MAX_ELEMENTS);
      end
      pat = fill_pattern_t'($urandom_range(0, 4));
      send_list(len, pat);
      list_no++;
    end
    item_ch.valid <= 1'b0;

    // Drain every predicted result, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsc_pkg.sv
rtl/bsc_in_if.sv
rtl/bsc_out_if.sv
rtl/bsc_ram.sv
rtl/bsc_front.sv
rtl/bsc_queue.sv
rtl/bsc_back.sv
rtl/bubble_sort_with_counts.sv
rtl/bsc_checker.sv
verif/bsc_sort_checker.sv
verif/tb_top.sv
